@@ src/dtt_pkg.sv @@
package dtt_pkg;

  localparam int TIME_W = 40;
  localparam int TAG_W  = 32;
  localparam int ID_W   = 6;
  localparam int WAIT_W = 20;
  localparam int OP_W   = 2;
  localparam int KIND_W = 2;

  localparam logic [WAIT_W-1:0] WAIT_RESET = WAIT_W'(250000);

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CANCEL,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] sched;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage

@@ src/deadline_timer_table.sv @@
// Deadline timer table.
// Input channel: an op (add, cancel, update) with its operands is taken at a
// clock edge where start is high and busy is low; op 3 is taken and dropped.
// Result channel: out_valid marks each result beat for exactly one cycle; the
// receiver must take every beat, it cannot stall the block. out_last flags
// the final beat of an op.
// Add and cancel: the op passes through its ADD or CANCEL state, which
// registers the result beat; busy is high only while in that state, and a
// new op can be taken again while that beat is shown.
// The start edge reads the free-id stack or the entry memory; the ADD or
// CANCEL state then writes back and reports.
// Update: the table is scanned one id per cycle, from id 0 up to the highest
// id ever handed out, through the entry memory read port. Fired timers come
// out one beat per cycle; the update done beat follows the scan, which stops
// below high_water, one above the highest id ever used (at most MAX_TIMERS).
// cfg_we writes max_wait at any edge; write it only while the block is idle.
// Reset clears all in-use bits and the free count, sets high_water to 1 and
// max_wait to 250000; the entry and stack memories need no clearing.
module deadline_timer_table
  import dtt_pkg::*;
#(
  parameter int MAX_TIMERS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   in_op,
  input  logic [TIME_W-1:0] in_deadline,
  input  logic [TAG_W-1:0]  in_user_tag,
  input  logic [ID_W-1:0]   in_cancel_id,
  input  logic [TIME_W-1:0] in_now_time,
  output logic              out_valid,
  output logic [KIND_W-1:0] out_kind,
  output logic [ID_W-1:0]   out_timer_id,
  output logic [TAG_W-1:0]  out_tag_out,
  output logic [TIME_W-1:0] out_fire_time,
  output logic [TIME_W-1:0] out_next_time,
  output logic              out_ok,
  output logic              out_wake,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic [WAIT_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_TIMERS);
  localparam int CNT_W = $clog2(MAX_TIMERS + 1);
  localparam int CMP_W = (ID_W > CNT_W) ? ID_W : CNT_W;

  // storage
  entry_t             ent_mem [MAX_TIMERS];
  logic [IDX_W-1:0]   fs_mem  [MAX_TIMERS];
  entry_t             ent_rd_r;
  logic [IDX_W-1:0]   fs_rd_r;

  state_t             state_r, state_nxt;
  logic [MAX_TIMERS-1:0] in_use_r, in_use_nxt;
  logic [CNT_W-1:0]   free_count_r, free_count_nxt;
  logic [CNT_W-1:0]   high_water_r, high_water_nxt;
  logic [TIME_W-1:0]  next_update_r, next_update_nxt;
  logic [WAIT_W-1:0]  max_wait_r;

  logic [TIME_W-1:0]  op_time_r, op_time_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               cancel_ok_r, cancel_ok_nxt;
  logic [TIME_W-1:0]  next_r, next_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic [TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic [TIME_W-1:0]  out_fire_r, out_fire_nxt;
  logic [TIME_W-1:0]  out_next_r, out_next_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic               out_wake_r, out_wake_nxt;
  logic               out_last_r, out_last_nxt;

  logic [IDX_W-1:0]   ent_raddr;
  logic               ent_we;
  logic [IDX_W-1:0]   ent_waddr;
  logic [IDX_W-1:0]   fs_raddr;
  logic               fs_we;
  logic [IDX_W-1:0]   fs_waddr;
  logic [IDX_W-1:0]   fs_wdata;

  logic [TIME_W:0]    sum_wait;
  logic [TIME_W-1:0]  sat_next;

  assign busy = (state_r != ST_IDLE);

  // now + max_wait, saturating at the largest time
  assign sum_wait = {1'b0, in_now_time} + (TIME_W + 1)'(max_wait_r);
  assign sat_next = sum_wait[TIME_W] ? {TIME_W{1'b1}} : sum_wait[TIME_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    in_use_nxt      = in_use_r;
    free_count_nxt  = free_count_r;
    high_water_nxt  = high_water_r;
    next_update_nxt = next_update_r;
    op_time_nxt     = op_time_r;
    tag_nxt         = tag_r;
    idx_nxt         = idx_r;
    cancel_ok_nxt   = cancel_ok_r;
    next_nxt        = next_r;

    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_tag_nxt   = out_tag_r;
    out_fire_nxt  = out_fire_r;
    out_next_nxt  = out_next_r;
    out_ok_nxt    = out_ok_r;
    out_wake_nxt  = out_wake_r;
    out_last_nxt  = out_last_r;

    ent_raddr = in_cancel_id[IDX_W-1:0];
    ent_we    = 1'b0;
    ent_waddr = idx_r;
    fs_raddr  = IDX_W'(free_count_r - CNT_W'(1));
    fs_we     = 1'b0;
    fs_waddr  = free_count_r[IDX_W-1:0];
    fs_wdata  = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          tag_nxt = in_user_tag;
          idx_nxt = in_cancel_id[IDX_W-1:0];
          cancel_ok_nxt = (in_cancel_id != '0) &&
                          (CMP_W'(in_cancel_id) < CMP_W'(high_water_r)) &&
                          in_use_r[in_cancel_id[IDX_W-1:0]];
          unique case (in_op)
            OP_ADD: begin
              op_time_nxt = in_deadline;
              state_nxt   = ST_ADD;
            end
            OP_CANCEL: begin
              state_nxt = ST_CANCEL;
            end
            OP_UPDATE: begin
              op_time_nxt = in_now_time;
              next_nxt    = sat_next;
              idx_nxt     = '0;
              ent_raddr   = '0;
              state_nxt   = ST_SCAN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_ADD: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_ADD;
        out_tag_nxt   = '0;
        out_fire_nxt  = '0;
        out_next_nxt  = '0;
        out_last_nxt  = 1'b1;
        out_ok_nxt    = 1'b1;
        out_wake_nxt  = (op_time_r < next_update_r);
        ent_we        = 1'b1;
        // last freed id first, then the next id never used
        if (free_count_r != '0) begin
          ent_waddr      = fs_rd_r;
          free_count_nxt = free_count_r - CNT_W'(1);
        end else if (high_water_r < CNT_W'(MAX_TIMERS)) begin
          ent_waddr      = high_water_r[IDX_W-1:0];
          high_water_nxt = high_water_r + CNT_W'(1);
        end else begin
          ent_we       = 1'b0;
          out_ok_nxt   = 1'b0;
          out_wake_nxt = 1'b0;
        end
        if (ent_we) begin
          in_use_nxt[ent_waddr] = 1'b1;
        end
        out_id_nxt = out_ok_nxt ? ID_W'(ent_waddr) : '0;
        state_nxt  = ST_IDLE;
      end

      ST_CANCEL: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_CANCEL;
        out_fire_nxt  = '0;
        out_next_nxt  = '0;
        out_wake_nxt  = 1'b0;
        out_last_nxt  = 1'b1;
        out_ok_nxt    = cancel_ok_r;
        out_id_nxt    = cancel_ok_r ? ID_W'(idx_r) : '0;
        out_tag_nxt   = cancel_ok_r ? ent_rd_r.tag : '0;
        if (cancel_ok_r) begin
          in_use_nxt[idx_r] = 1'b0;
          if (free_count_r < CNT_W'(MAX_TIMERS)) begin
            fs_we          = 1'b1;
            free_count_nxt = free_count_r + CNT_W'(1);
          end
        end
        state_nxt = ST_IDLE;
      end

      ST_SCAN: begin
        // ent_rd_r holds entry idx_r; fetch the following one
        ent_raddr = IDX_W'(idx_r + IDX_W'(1));
        if (in_use_r[idx_r]) begin
          if (ent_rd_r.sched <= op_time_r) begin
            out_valid_nxt     = 1'b1;
            out_kind_nxt      = KIND_FIRE;
            out_id_nxt        = ID_W'(idx_r);
            out_tag_nxt       = ent_rd_r.tag;
            out_fire_nxt      = ent_rd_r.sched;
            out_next_nxt      = '0;
            out_ok_nxt        = 1'b0;
            out_wake_nxt      = 1'b0;
            out_last_nxt      = 1'b0;
            in_use_nxt[idx_r] = 1'b0;
            if (free_count_r < CNT_W'(MAX_TIMERS)) begin
              fs_we          = 1'b1;
              free_count_nxt = free_count_r + CNT_W'(1);
            end
          end else if (ent_rd_r.sched <= next_r) begin
            next_nxt = ent_rd_r.sched;
          end
        end
        if (CNT_W'(idx_r) + CNT_W'(1) == high_water_r) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = IDX_W'(idx_r + IDX_W'(1));
        end
      end

      ST_DONE: begin
        out_valid_nxt   = 1'b1;
        out_kind_nxt    = KIND_UPDATE;
        out_id_nxt      = '0;
        out_tag_nxt     = '0;
        out_fire_nxt    = '0;
        out_next_nxt    = next_r;
        out_ok_nxt      = 1'b0;
        out_wake_nxt    = 1'b0;
        out_last_nxt    = 1'b1;
        next_update_nxt = next_r;
        state_nxt       = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // entry memory: sched time and tag per id
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= '{sched: op_time_r, tag: tag_r};
    end
    ent_rd_r <= ent_mem[ent_raddr];
  end

  // free-id stack
  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    fs_rd_r <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      in_use_r      <= '0;
      free_count_r  <= '0;
      high_water_r  <= CNT_W'(1);
      next_update_r <= '0;
      max_wait_r    <= WAIT_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      in_use_r      <= in_use_nxt;
      free_count_r  <= free_count_nxt;
      high_water_r  <= high_water_nxt;
      next_update_r <= next_update_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        max_wait_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_time_r   <= op_time_nxt;
    tag_r       <= tag_nxt;
    idx_r       <= idx_nxt;
    cancel_ok_r <= cancel_ok_nxt;
    next_r      <= next_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_tag_r   <= out_tag_nxt;
    out_fire_r  <= out_fire_nxt;
    out_next_r  <= out_next_nxt;
    out_ok_r    <= out_ok_nxt;
    out_wake_r  <= out_wake_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_timer_id  = out_id_r;
  assign out_tag_out   = out_tag_r;
  assign out_fire_time = out_fire_r;
  assign out_next_time = out_next_r;
  assign out_ok        = out_ok_r;
  assign out_wake      = out_wake_r;
  assign out_last      = out_last_r;

  // every free id is distinct and below high_water, never the null id
  a_free_below_hw: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r < high_water_r)
    else $error("free stack deeper than the ids handed out");

  a_null_unused: assert property (@(posedge clk) disable iff (!rst_n)
    !in_use_r[0])
    else $error("null timer marked in use");

  a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |=> out_valid_r && out_last_r && out_kind_r == KIND_UPDATE)
    else $error("update scan ended without its done beat");

  a_add_beat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == OP_ADD |-> ##2 out_valid_r && out_kind_r == KIND_ADD)
    else $error("add gave no result two cycles later");

endmodule
